// ===== src/twce_pkg.sv =====
// shared types and constants of the text window character engine
// no dependencies; imported by the engine top level

package twce_pkg;

	// command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_LINE_WIDTH  = 3'd0,
		REG_VIEW_HEIGHT = 3'd1,
		REG_TOTAL_LINES = 3'd2,
		REG_ORIGIN_COL  = 3'd3,
		REG_ORIGIN_ROW  = 3'd4
	} reg_idx_t;

	// control characters and the space
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_ESC   = 16'h001b;
	localparam logic [15:0] CH_BS    = 16'h0008;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_LF    = 16'h000a;
	localparam logic [15:0] CH_CR    = 16'h000d;

	localparam logic [15:0] DEFAULT_ATTR = 16'h0007;

	// register reset values
	localparam logic [7:0] RST_LINE_WIDTH  = 8'd80;
	localparam logic [6:0] RST_VIEW_HEIGHT = 7'd25;
	localparam logic [6:0] RST_TOTAL_LINES = 7'd64;

	// stream widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 88;

endpackage

// ===== src/twce_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module twce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/text_window_character_engine_unit.sv =====
// top level of the text window character engine: cell store, cursor, view and
// attribute control, apb register file and stream ports
// depends on twce_pkg and twce_ram

// The engine keeps a store of MAX_LINES rows by MAX_COLS columns of cells (16-bit
// character and 16-bit attribute) in one simple dual-port ram, plus a cursor, the
// first row shown in the window and the current attribute. Each input transaction
// carries a command in s_tuser (write character, read cell, clear store) and gives
// exactly one output transaction with the cell read, the cursor and the view. Items
// are handled one at a time by a sequencer that works on the ram one cell a cycle;
// a tab writes one space at a time up to the next tab stop, at most TAB_STOP. When
// the cursor passes the last row the store is shifted up through the ram's read and
// write ports, one cell a cycle: the rows are copied one row up (no copy with a
// single line), then the freed last row is blanked across the effective line width.
// Clear sweeps every cell. After reset the same sweep loads spaces with attribute
// 0x07, during which no item is accepted; configuration writes are taken at any time
// but must only be issued while idle.
// A finished result waits in the output register while the next item is accepted.

module text_window_character_engine_unit #(
	parameter int MAX_COLS  = 128,
	parameter int MAX_LINES = 64,
	parameter int TAB_STOP  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [4:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// code[15:0], fill_attr[31:16], cell_row[37:32], cell_col[44:38], zero pad
	input  logic [twce_pkg::IN_DATA_W-1:0]   s_tdata,
	// command[1:0]
	input  logic [1:0]                       s_tuser,
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// cell_char[15:0], cell_attr[31:16], cursor_col[38:32], cursor_row[44:39],
	// view_top[50:45], screen_col[59:51], screen_row[68:60], current_attr[84:69]
	output logic [twce_pkg::OUT_DATA_W-1:0]  m_tdata
);

	import twce_pkg::*;

	localparam int CELLS = MAX_COLS * MAX_LINES;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int PW    = $clog2(CELLS + 1);
	// column domain covers the tab stop beyond the line end
	localparam int CB    = $clog2(MAX_COLS + TAB_STOP + 1);
	localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	// row domain covers the effective line count itself
	localparam int RB    = $clog2(MAX_LINES + 1);
	localparam int NB    = $clog2(TAB_STOP + 1);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_EXEC, ST_TAB, ST_SCR, ST_SCRT, ST_BLANK,
		ST_FILL, ST_RD, ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0] line_width_q;
	logic [6:0] view_height_q;
	logic [6:0] total_lines_q;
	logic [7:0] origin_col_q;
	logic [7:0] origin_row_q;

	// engine state
	logic [CB-1:0] x_q;
	logic [RB-1:0] y_q;
	logic [RB-1:0] top_q;
	logic [15:0]   attr_q;
	logic          esc_q;

	// latched item
	cmd_t          cmd_q;
	logic [15:0]   code_q;
	logic [15:0]   fattr_q;
	logic [5:0]    row_q;
	logic [6:0]    col_q;

	// sequencer
	logic [CB-1:0] stop_q;
	logic [NB-1:0] n_q;
	logic          ret_tab_q;
	logic [PW-1:0] ptr_q;
	logic          wpend_s1;
	logic [AW-1:0] wpaddr_s1;
	logic [15:0]   rch_q;
	logic [15:0]   rat_q;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	twce_ram #(
		.WIDTH (32),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	function automatic logic [AW-1:0] cell_addr(input logic [RB-1:0] r,
		input logic [CB-1:0] c);
		cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
	endfunction

	// next tab stop for each column
	logic [CB-1:0] stop_lut [MAX_COLS];
	for (genvar gi = 0; gi < MAX_COLS; gi++) begin : g_stop
		localparam int STOP_V = (gi / TAB_STOP + 1) * TAB_STOP;
		assign stop_lut[gi] = CB'(STOP_V);
	end

	// effective sizes, zero counts as one, larger values clamped to the store
	logic [15:0]   lw16, tl16, vh16, w16, l16, h16;
	logic [CB-1:0] eff_w;
	logic [RB-1:0] eff_l, eff_h;

	always_comb begin
		lw16 = 16'(line_width_q);
		tl16 = 16'(total_lines_q);
		vh16 = 16'(view_height_q);
		w16  = (lw16 == 16'd0) ? 16'd1 : ((lw16 > 16'(MAX_COLS)) ? 16'(MAX_COLS) : lw16);
		l16  = (tl16 == 16'd0) ? 16'd1 : ((tl16 > 16'(MAX_LINES)) ? 16'(MAX_LINES) : tl16);
		h16  = (vh16 == 16'd0) ? 16'd1 : ((vh16 > l16) ? l16 : vh16);
		eff_w = CB'(w16);
		eff_l = RB'(l16);
		eff_h = RB'(h16);
	end

	// cursor and view limited to the current sizes, applied as an item enters
	logic [CB-1:0] nrm_x;
	logic [RB-1:0] nrm_y, nrm_top, lmh, t0, t1;

	always_comb begin
		nrm_x   = (x_q >= eff_w) ? eff_w - CB'(1) : x_q;
		nrm_y   = (y_q >= eff_l) ? eff_l - RB'(1) : y_q;
		lmh     = eff_l - eff_h;
		t0      = (top_q > lmh) ? lmh : top_q;
		t1      = (nrm_y < t0) ? nrm_y : t0;
		nrm_top = (nrm_y >= t1 + eff_h) ? nrm_y - eff_h + RB'(1) : t1;
	end

	// one column forward, with wrap, view move or store scroll
	logic [CB-1:0] adv_xi, adv_x;
	logic [RB-1:0] adv_y, adv_top, y1, top_h;
	logic          adv_wrap, adv_scroll;
	logic [RB-1:0] ld_y, ld_top;
	logic          ld_scroll;

	always_comb begin
		// line down from the current row
		y1    = y_q + RB'(1);
		top_h = top_q + eff_h;
		ld_y      = y1;
		ld_top    = top_q;
		ld_scroll = 1'b0;
		if (y1 >= top_h) begin
			if (top_h < eff_l) begin
				ld_top = top_q + RB'(1);
			end else begin
				ld_y      = y_q;
				ld_scroll = 1'b1;
			end
		end
		adv_xi   = x_q + CB'(1);
		adv_wrap = (adv_xi >= eff_w);
		adv_x    = adv_wrap ? '0 : adv_xi;
		adv_y      = adv_wrap ? ld_y : y_q;
		adv_top    = adv_wrap ? ld_top : top_q;
		adv_scroll = adv_wrap & ld_scroll;
	end

	logic [CB-1:0] bs_x;
	logic [CB-1:0] stop_n;
	logic          tab_go;
	logic          rd_hit;
	logic [AW-1:0] last_base;
	logic [PW-1:0] scr_end;

	assign bs_x      = (x_q != '0) ? x_q - CB'(1) : x_q;
	assign stop_n    = (adv_x == '0 && stop_q >= eff_w) ? stop_q - eff_w : stop_q;
	assign tab_go    = (32'(n_q) < TAB_STOP) && (x_q < stop_q);
	assign rd_hit    = (16'(row_q) < 16'(eff_l)) && (16'(col_q) < 16'(eff_w));
	assign last_base = AW'(32'(eff_l - RB'(1)) * MAX_COLS);
	assign scr_end   = PW'(32'(eff_l) * MAX_COLS - 1);

	// ram port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr(y_q, x_q);
		ram_wdata = {attr_q, CH_SPACE};
		ram_raddr = AW'(ptr_q);
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(ptr_q);
				ram_wdata = {DEFAULT_ATTR, CH_SPACE};
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(ptr_q);
				ram_wdata = {fattr_q, code_q};
			end
			ST_EXEC: begin
				ram_raddr = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
				if (cmd_q == CMD_WRITE && !esc_q) begin
					case (code_q)
						CH_ESC, CH_LF, CH_CR, CH_TAB: ram_we = 1'b0;
						CH_BS: begin
							ram_we    = 1'b1;
							ram_waddr = cell_addr(y_q, bs_x);
						end
						default: begin
							ram_we    = 1'b1;
							ram_wdata = {attr_q, code_q};
						end
					endcase
				end
			end
			ST_TAB: ram_we = tab_go;
			ST_SCR, ST_SCRT: begin
				// copy of the cell read in the cycle before
				ram_we    = wpend_s1;
				ram_waddr = wpaddr_s1;
				ram_wdata = ram_rdata;
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = last_base + AW'(ptr_q);
			end
			default: ram_we = 1'b0;
		endcase
	end

	// configuration port
	logic       cfg_wr;
	reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			REG_LINE_WIDTH:  prdata = 32'(line_width_q);
			REG_VIEW_HEIGHT: prdata = 32'(view_height_q);
			REG_TOTAL_LINES: prdata = 32'(total_lines_q);
			REG_ORIGIN_COL:  prdata = 32'(origin_col_q);
			REG_ORIGIN_ROW:  prdata = 32'(origin_row_q);
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= RST_LINE_WIDTH;
			view_height_q <= RST_VIEW_HEIGHT;
			total_lines_q <= RST_TOTAL_LINES;
			origin_col_q  <= '0;
			origin_row_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LINE_WIDTH:  line_width_q  <= pwdata[7:0];
				REG_VIEW_HEIGHT: view_height_q <= pwdata[6:0];
				REG_TOTAL_LINES: total_lines_q <= pwdata[6:0];
				REG_ORIGIN_COL:  origin_col_q  <= pwdata[7:0];
				REG_ORIGIN_ROW:  origin_row_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// stream handshakes
	logic s_acc;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// result fields
	logic [8:0] scol, srow;
	assign scol = 9'(16'(origin_col_q) + 16'(x_q));
	assign srow = 9'(16'(origin_row_q) + 16'(y_q) - 16'(top_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			x_q        <= '0;
			y_q        <= '0;
			top_q      <= '0;
			attr_q     <= DEFAULT_ATTR;
			esc_q      <= 1'b0;
			ptr_q      <= '0;
			wpend_s1   <= 1'b0;
			ret_tab_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			cmd_q      <= CMD_NONE;
		end else begin
			// a result loaded in ST_DONE takes over the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			// scroll copy pipeline: the write follows its read in the next cycle
			wpend_s1  <= (state_q == ST_SCR);
			wpaddr_s1 <= AW'(ptr_q - PW'(MAX_COLS));
			case (state_q)
				ST_INIT: begin
					// load of the reset contents
					if (ptr_q == PW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						cmd_q   <= cmd_t'(s_tuser);
						code_q  <= s_tdata[15:0];
						fattr_q <= s_tdata[31:16];
						row_q   <= s_tdata[37:32];
						col_q   <= s_tdata[44:38];
						x_q     <= nrm_x;
						y_q     <= nrm_y;
						top_q   <= nrm_top;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rch_q   <= '0;
					rat_q   <= '0;
					case (cmd_q)
						CMD_WRITE: begin
							if (esc_q) begin
								attr_q  <= code_q;
								esc_q   <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								case (code_q)
									CH_ESC: begin
										esc_q   <= 1'b1;
										state_q <= ST_DONE;
									end
									CH_CR: begin
										x_q     <= '0;
										state_q <= ST_DONE;
									end
									CH_BS: begin
										x_q     <= bs_x;
										state_q <= ST_DONE;
									end
									CH_LF: begin
										x_q   <= '0;
										y_q   <= ld_y;
										top_q <= ld_top;
										if (ld_scroll) begin
											ret_tab_q <= 1'b0;
											ptr_q     <= (eff_l == RB'(1)) ? '0 : PW'(MAX_COLS);
											state_q   <= (eff_l == RB'(1)) ? ST_BLANK : ST_SCR;
										end else begin
											state_q <= ST_DONE;
										end
									end
									CH_TAB: begin
										stop_q  <= stop_lut[x_q[XW-1:0]];
										n_q     <= '0;
										state_q <= ST_TAB;
									end
									default: begin
										x_q   <= adv_x;
										y_q   <= adv_y;
										top_q <= adv_top;
										if (adv_scroll) begin
											ret_tab_q <= 1'b0;
											ptr_q     <= (eff_l == RB'(1)) ? '0 : PW'(MAX_COLS);
											state_q   <= (eff_l == RB'(1)) ? ST_BLANK : ST_SCR;
										end else begin
											state_q <= ST_DONE;
										end
									end
								endcase
							end
						end
						CMD_READ: begin
							state_q <= rd_hit ? ST_RD : ST_DONE;
						end
						CMD_CLEAR: begin
							attr_q  <= fattr_q;
							x_q     <= '0;
							y_q     <= '0;
							top_q   <= '0;
							esc_q   <= 1'b0;
							ptr_q   <= '0;
							state_q <= ST_FILL;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_TAB: begin
					// one space per cycle up to the stop, paused while a scroll runs
					if (tab_go) begin
						x_q    <= adv_x;
						y_q    <= adv_y;
						top_q  <= adv_top;
						n_q    <= n_q + NB'(1);
						stop_q <= stop_n;
						if (adv_scroll) begin
							ret_tab_q <= 1'b1;
							ptr_q     <= (eff_l == RB'(1)) ? '0 : PW'(MAX_COLS);
							state_q   <= (eff_l == RB'(1)) ? ST_BLANK : ST_SCR;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCR: begin
					// read source row below, written back one row up
					if (ptr_q == scr_end) begin
						state_q <= ST_SCRT;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_SCRT: begin
					ptr_q   <= '0;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					// freed last row gets spaces with the current attribute
					if (ptr_q == PW'(eff_w - CB'(1))) begin
						state_q <= ret_tab_q ? ST_TAB : ST_DONE;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_FILL: begin
					if (ptr_q == PW'(CELLS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				ST_RD: begin
					rch_q   <= ram_rdata[15:0];
					rat_q   <= ram_rdata[31:16];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// result waits for a free output register
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'd0, attr_q, srow, scol, 6'(top_q), 6'(y_q),
							7'(x_q), rat_q, rch_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
